// ----- hdl/csvt_pkg.sv -----
// Package for the CSV record tokenizer: word types, character and code constants,
// parse state type and the whitespace classifier.
// Used by csvt_core, csvt_outq and csv_record_tokenizer.
package csvt_pkg;

    // Record counter width (saturating counter)
    localparam int RecW = 20;

    // Config register indexes
    localparam logic [1:0] REG_MAX_COLUMNS      = 2'd0;
    localparam logic [1:0] REG_MAX_FIELD_LENGTH = 2'd1;
    localparam logic [1:0] REG_MAX_RECORDS      = 2'd2;

    // Config reset values
    localparam logic [10:0] MAX_COLUMNS_RST      = 11'd256;
    localparam logic [15:0] MAX_FIELD_LENGTH_RST = 16'd4096;
    localparam logic [15:0] MAX_RECORDS_RST      = 16'd10001;

    // Input commands
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_DATA  = 3'd0;
    localparam logic [2:0] KIND_FIELD = 3'd1;
    localparam logic [2:0] KIND_ROW   = 3'd2;
    localparam logic [2:0] KIND_ERR   = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_COLUMNS  = 3'd0;
    localparam logic [2:0] ERR_RECORDS  = 3'd1;
    localparam logic [2:0] ERR_FLONG    = 3'd2;
    localparam logic [2:0] ERR_AFTER_Q  = 3'd3;
    localparam logic [2:0] ERR_STRAY_Q  = 3'd4;
    localparam logic [2:0] ERR_UNTERM   = 3'd5;

    // Special characters
    localparam logic [15:0] CH_QUOTE = 16'h0022;
    localparam logic [15:0] CH_COMMA = 16'h002C;
    localparam logic [15:0] CH_CR    = 16'h000D;
    localparam logic [15:0] CH_LF    = 16'h000A;

    typedef enum logic [1:0] {
        ST_START  = 2'd0,
        ST_PLAIN  = 2'd1,
        ST_QUOTED = 2'd2,
        ST_CLOSED = 2'd3
    } parse_state_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] char_code;
    } char_word_t;

    typedef struct packed {
        logic [2:0]      kind;
        logic [15:0]     out_char;
        logic [RecW-1:0] record_number;
        logic [2:0]      error_code;
        logic            blank_record;
        logic            last;
    } tok_word_t;

    // Results of one input word: count (0..2) and up to two words
    typedef struct packed {
        logic [1:0] cnt;
        tok_word_t  w0;
        tok_word_t  w1;
    } res_pair_t;

    // Unicode whitespace set used for blank-record detection
    function automatic logic is_ws(input logic [15:0] c);
        logic ws;
        ws = (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085
            || c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A)
            || c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F
            || c == 16'h3000;
        return ws;
    endfunction

endpackage

// ----- hdl/csv_record_tokenizer.sv -----
// Top level of the CSV record tokenizer: parser core plus result queue.
// Depends on csvt_pkg, csvt_core and csvt_outq.
//
// Usage:
//   char channel (char_valid / char_stall / char_word): one word is a UTF-16 code
//   unit (cmd = character) or an end-of-input command.
//   tok channel (tok_valid / tok_stall / tok_word): data characters, field ends,
//   record ends, errors and input done; last marks the final word of an input.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): limit registers,
//   index 0 max columns, 1 max field length, 2 max records. cfg_ready is always
//   high; write only while the block is idle.
// Timing:
//   An input word is parsed in the cycle it is accepted; its results are registered
//   in the result queue and presented on tok from its head. One word per cycle is
//   sustained while tok is not stalled; an end of input that flushes an open record
//   yields two words, which the single-word output port presents one at a time.
// Reset clears the parse state, counters and queue; limits return to 256, 4096
// and 10001. When tok is stalled, the three-word result queue fills and
// char_stall rises once fewer than two free entries remain.
module csv_record_tokenizer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  csvt_pkg::char_word_t  char_word,
    output logic                  tok_valid,
    input  logic                  tok_stall,
    output csvt_pkg::tok_word_t   tok_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);
    import csvt_pkg::*;

    res_pair_t res;
    logic      halted;
    logic      accept;
    logic      full;

    assign cfg_ready  = 1'b1;
    assign char_stall = full;
    assign accept     = char_valid && !full;

    csvt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_word (char_word),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res),
        .halted    (halted)
    );

    csvt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .res       (res),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_word  (tok_word),
        .full      (full)
    );

    // Once halted, the core produces nothing more
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        halted |-> res.cnt == 2'd0)
        else $error("results produced while halted");

    // Errors and input done always close out their input word
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (tok_word.kind == KIND_ERR || tok_word.kind == KIND_DONE)
        |-> tok_word.last)
        else $error("error or done word without last");

    // A record end that is not last is the flush of end of input: done follows
    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_stall && tok_word.kind == KIND_ROW && !tok_word.last
        |=> tok_valid && tok_word.kind == KIND_DONE)
        else $error("flushed record end not followed by input done");

endmodule

// ----- hdl/csvt_core.sv -----
// Parser core: config registers, parse state and counters, and the combinational
// decode of one input word into up to two result words.
// Depends on csvt_pkg.
module csvt_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  csvt_pkg::char_word_t   char_word,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    output csvt_pkg::res_pair_t    res,
    output logic                   halted
);
    import csvt_pkg::*;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_OPEN,
        ACT_CLOSE,
        ACT_DATA,
        ACT_FIELD,
        ACT_ROW,
        ACT_FAIL,
        ACT_DONE,
        ACT_DONE_ROW
    } act_t;

    logic [10:0]     max_cols_reg;
    logic [15:0]     max_flen_reg;
    logic [15:0]     max_recs_reg;

    parse_state_t    parse_reg, parse_next;
    logic            skip_reg, skip_next;
    logic [15:0]     flen_reg, flen_next;
    logic [10:0]     cols_reg, cols_next;
    logic [15:0]     kept_reg, kept_next;
    logic [RecW-1:0] recno_reg, recno_next;
    logic            text_reg, text_next;
    logic            halted_reg, halted_next;

    act_t            act;
    logic [2:0]      err;

    logic [15:0]     c;
    logic [16:0]     nl;
    logic [11:0]     nc;
    logic [16:0]     nk;
    logic            fl_over, col_over, rec_over, flush;
    logic            is_q, is_comma, is_eol;
    logic [RecW-1:0] rc_inc;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cols_reg <= MAX_COLUMNS_RST;
            max_flen_reg <= MAX_FIELD_LENGTH_RST;
            max_recs_reg <= MAX_RECORDS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_COLUMNS:      max_cols_reg <= cfg_data[10:0];
                REG_MAX_FIELD_LENGTH: max_flen_reg <= cfg_data;
                REG_MAX_RECORDS:      max_recs_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Shared increments and limit checks
    always_comb
    begin
        c        = char_word.char_code;
        nl       = {1'b0, flen_reg} + 17'd1;
        nc       = {1'b0, cols_reg} + 12'd1;
        nk       = {1'b0, kept_reg} + 17'd1;
        fl_over  = nl > {1'b0, max_flen_reg};
        col_over = nc > {1'b0, max_cols_reg};
        rec_over = text_reg && (nk > {1'b0, max_recs_reg});
        rc_inc   = (recno_reg == {RecW{1'b1}}) ? recno_reg : recno_reg + RecW'(1);
        flush    = (parse_reg != ST_START) || (flen_reg != 16'd0) || (cols_reg != 11'd0);
        is_q     = c == CH_QUOTE;
        is_comma = c == CH_COMMA;
        is_eol   = (c == CH_CR) || (c == CH_LF);
    end

    // Decode: pick the action for this word
    always_comb
    begin
        act = ACT_NONE;
        err = ERR_COLUMNS;
        if (halted_reg)
        begin
            act = ACT_NONE;
        end
        else if (char_word.cmd == CMD_END)
        begin
            if (parse_reg == ST_QUOTED)
            begin
                act = ACT_FAIL;
                err = ERR_UNTERM;
            end
            else if (flush)
            begin
                if (col_over)
                begin
                    act = ACT_FAIL;
                    err = ERR_COLUMNS;
                end
                else if (rec_over)
                begin
                    act = ACT_FAIL;
                    err = ERR_RECORDS;
                end
                else
                begin
                    act = ACT_DONE_ROW;
                end
            end
            else
            begin
                act = ACT_DONE;
            end
        end
        else if (skip_reg && c == CH_LF)
        begin
            act = ACT_NONE;
        end
        else if (parse_reg == ST_QUOTED && is_q)
        begin
            act = ACT_CLOSE;
        end
        else if (parse_reg == ST_QUOTED || (parse_reg == ST_CLOSED && is_q))
        begin
            act = fl_over ? ACT_FAIL : ACT_DATA;
            err = ERR_FLONG;
        end
        else if (is_comma)
        begin
            act = col_over ? ACT_FAIL : ACT_FIELD;
            err = ERR_COLUMNS;
        end
        else if (is_eol)
        begin
            if (col_over)
            begin
                act = ACT_FAIL;
                err = ERR_COLUMNS;
            end
            else if (rec_over)
            begin
                act = ACT_FAIL;
                err = ERR_RECORDS;
            end
            else
            begin
                act = ACT_ROW;
            end
        end
        else if (parse_reg == ST_CLOSED)
        begin
            act = ACT_FAIL;
            err = ERR_AFTER_Q;
        end
        else if (is_q)
        begin
            act = (parse_reg == ST_START) ? ACT_OPEN : ACT_FAIL;
            err = ERR_STRAY_Q;
        end
        else
        begin
            act = fl_over ? ACT_FAIL : ACT_DATA;
            err = ERR_FLONG;
        end
    end

    // Next state
    always_comb
    begin
        parse_next  = parse_reg;
        skip_next   = skip_reg;
        flen_next   = flen_reg;
        cols_next   = cols_reg;
        kept_next   = kept_reg;
        recno_next  = recno_reg;
        text_next   = text_reg;
        halted_next = halted_reg;
        if (accept)
        begin
            skip_next = 1'b0;
            unique case (act)
                ACT_NONE:  ;
                ACT_OPEN:  parse_next = ST_QUOTED;
                ACT_CLOSE: parse_next = ST_CLOSED;
                ACT_DATA:
                begin
                    // plain text stays plain; quoted or escaped quote stays quoted
                    parse_next = (parse_reg == ST_START || parse_reg == ST_PLAIN) ?
                                 ST_PLAIN : ST_QUOTED;
                    flen_next  = nl[15:0];
                    text_next  = text_reg | ~is_ws(c);
                end
                ACT_FIELD:
                begin
                    parse_next = ST_START;
                    cols_next  = nc[10:0];
                    flen_next  = 16'd0;
                end
                ACT_ROW:
                begin
                    parse_next = ST_START;
                    flen_next  = 16'd0;
                    cols_next  = 11'd0;
                    text_next  = 1'b0;
                    recno_next = rc_inc;
                    kept_next  = text_reg ? nk[15:0] : kept_reg;
                    skip_next  = c == CH_CR;
                end
                ACT_FAIL:  halted_next = 1'b1;
                ACT_DONE, ACT_DONE_ROW:
                begin
                    parse_next = ST_START;
                    flen_next  = 16'd0;
                    cols_next  = 11'd0;
                    kept_next  = 16'd0;
                    recno_next = RecW'(1);
                    text_next  = 1'b0;
                end
                default:   ;
            endcase
        end
    end

    // Result words
    always_comb
    begin
        res    = '0;
        res.w0.record_number = recno_reg;
        unique case (act)
            ACT_NONE, ACT_OPEN, ACT_CLOSE: res.cnt = 2'd0;
            ACT_DATA:
            begin
                res.cnt         = 2'd1;
                res.w0.kind     = KIND_DATA;
                res.w0.out_char = c;
                res.w0.last     = 1'b1;
            end
            ACT_FIELD:
            begin
                res.cnt     = 2'd1;
                res.w0.kind = KIND_FIELD;
                res.w0.last = 1'b1;
            end
            ACT_ROW:
            begin
                res.cnt             = 2'd1;
                res.w0.kind         = KIND_ROW;
                res.w0.blank_record = ~text_reg;
                res.w0.last         = 1'b1;
            end
            ACT_FAIL:
            begin
                // a record-limit error already counts the ended record
                res.cnt              = 2'd1;
                res.w0.kind          = KIND_ERR;
                res.w0.error_code    = err;
                res.w0.record_number = (err == ERR_RECORDS) ? rc_inc : recno_reg;
                res.w0.last          = 1'b1;
            end
            ACT_DONE:
            begin
                res.cnt     = 2'd1;
                res.w0.kind = KIND_DONE;
                res.w0.last = 1'b1;
            end
            ACT_DONE_ROW:
            begin
                res.cnt              = 2'd2;
                res.w0.kind          = KIND_ROW;
                res.w0.blank_record  = ~text_reg;
                res.w1.kind          = KIND_DONE;
                res.w1.record_number = rc_inc;
                res.w1.last          = 1'b1;
            end
            default: res.cnt = 2'd0;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg  <= ST_START;
            skip_reg   <= 1'b0;
            flen_reg   <= 16'd0;
            cols_reg   <= 11'd0;
            kept_reg   <= 16'd0;
            recno_reg  <= RecW'(1);
            text_reg   <= 1'b0;
            halted_reg <= 1'b0;
        end
        else
        begin
            parse_reg  <= parse_next;
            skip_reg   <= skip_next;
            flen_reg   <= flen_next;
            cols_reg   <= cols_next;
            kept_reg   <= kept_next;
            recno_reg  <= recno_next;
            text_reg   <= text_next;
            halted_reg <= halted_next;
        end
    end

    assign halted = halted_reg;

endmodule

// ----- hdl/csvt_outq.sv -----
// Three-word result queue between the parser core and the output channel.
// Takes up to two words per cycle, presents one. Depends on csvt_pkg.
module csvt_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  csvt_pkg::res_pair_t   res,
    output logic                  tok_valid,
    input  logic                  tok_stall,
    output csvt_pkg::tok_word_t   tok_word,
    output logic                  full
);
    import csvt_pkg::*;

    tok_word_t  q_reg [3];
    tok_word_t  q_next [3];
    tok_word_t  shifted [3];
    logic [1:0] count_reg, count_next;
    logic [1:0] base;
    logic [1:0] n_push;
    logic       pop;

    // Pop the head, shift down, then append new words
    always_comb
    begin
        pop        = (count_reg != 2'd0) && !tok_stall;
        base       = count_reg - {1'b0, pop};
        n_push     = push ? res.cnt : 2'd0;
        shifted[0] = pop ? q_reg[1] : q_reg[0];
        shifted[1] = pop ? q_reg[2] : q_reg[1];
        shifted[2] = q_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            q_next[i] = shifted[i];
            if (n_push != 2'd0 && 2'(i) == base)
                q_next[i] = res.w0;
            if (n_push == 2'd2 && 2'(i) == base + 2'd1)
                q_next[i] = res.w1;
        end
        count_next = base + n_push;
    end

    // Payload entries
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            q_reg[i] <= q_next[i];
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    assign tok_valid = count_reg != 2'd0;
    assign tok_word  = q_reg[0];
    assign full      = count_reg > 2'd1;

endmodule
